/* rtl/zorc_pkg.sv */
// ----------------------------------------------------------------------------
// zorc_pkg: shared types and constants of the zero/one run code decoder
// field widths, error codes, register index, sequencer states, result word
// ----------------------------------------------------------------------------
package zorc_pkg;

  localparam int MAX_PREFIX  = 47;
  localparam int BYTE_W      = 8;
  localparam int RUN_LEN_W   = 49;
  localparam int ERR_W       = 3;
  localparam int LIMIT_W     = 56;
  localparam int TOTAL_W     = 64;
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 4;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 3;

  // register index, taken from paddr[3]
  localparam logic REG_BIT_LIMIT = 1'b0;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK         = 3'd0,
    ERR_INCOMPLETE = 3'd1,
    ERR_NOT_BYTES  = 3'd2,
    ERR_LIMIT      = 3'd3,
    ERR_PREFIX     = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BITS,
    ST_CHECK,
    ST_END,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [RUN_LEN_W-1:0] run_length;
    logic                 run_is_ones;
    logic                 run_valid;
    logic                 stream_done;
    err_e                 error_code;
  } result_t;

  // requests from the sequencer to the output stage
  typedef struct packed {
    logic push;
    logic flush;
  } ostage_ctrl_t;

  // status of the output stage back to the sequencer
  typedef struct packed {
    logic can_push;
    logic pend_valid;
  } ostage_stat_t;

endpackage

/* rtl/zorc_out_stage.sv */
// ----------------------------------------------------------------------------
// zorc_out_stage: result holding and output register
// keeps the newest result back until the byte ends so that it can be tagged
// as the last one, and drives the master stream from a register
// ----------------------------------------------------------------------------
module zorc_out_stage
  import zorc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ostage_ctrl_t           ctrl_i,
  input  result_t                res_i,
  output ostage_stat_t           stat_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // run_length, error_code, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // run_is_ones, run_valid, stream_done
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  logic    pend_valid_q, pend_valid_d;
  result_t pend_q, pend_d;
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  logic    out_last_q, out_last_d;
  logic    out_free;
  logic    can_push;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign can_push = !pend_valid_q || out_free;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_d        = out_q;
    out_last_d   = out_last_q;
    if (ctrl_i.push && can_push) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = pend_q;
        out_last_d  = 1'b0;
      end
      pend_d       = res_i;
      pend_valid_d = 1'b1;
    end else if (ctrl_i.flush && pend_valid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign stat_o.can_push   = can_push;
  assign stat_o.pend_valid = pend_valid_q;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - RUN_LEN_W - ERR_W){1'b0}},
                            out_q.error_code, out_q.run_length};
  assign m_axis_tuser_o  = {out_q.stream_done, out_q.run_valid, out_q.run_is_ones};
  assign m_axis_tlast_o  = out_last_q;

endmodule

/* rtl/zero_one_run_code_decoder_unit.sv */
// ----------------------------------------------------------------------------
// zero_one_run_code_decoder_unit: bit-serial zero/one run code decoder
// walks each encoded byte msb first through a shift register, one code bit
// per cycle while not stalled, and emits alternating zero and one runs plus a final status word
// ----------------------------------------------------------------------------
// sequence: a byte is taken in the idle state, walked bit by bit in the bit
//   state, then passes the end and flush states; its last word moves to the
//   output register in the flush state
// byte overlap: none; a new byte is taken only in the idle state, after the
//   last one has been flushed; with a nonzero bit limit each decoded run adds
//   a pass through the limit compare state, and a stalled output holds the walk
// a byte arriving after decoding has stopped is taken and dropped in the idle state
// reset: asynchronous, active low; clears the sequencer, the decode state and
//   the bit limit register, output stage is empty

module zero_one_run_code_decoder_unit
  import zorc_pkg::*;
#(
  parameter int MaxPrefix = MAX_PREFIX
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input byte stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // code_byte
  input  logic [BYTE_W-1:0]      s_axis_tdata_i,
  // final_byte
  input  logic                   s_axis_tlast_i,
  // decoded run stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // run_length [48:0], error_code [51:49], zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // run_is_ones [0], run_valid [1], stream_done [2]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  // last_of_item
  output logic                   m_axis_tlast_o,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  // prefix counter saturates at MaxPrefix+1
  localparam int PC_W   = $clog2(MaxPrefix + 2);
  // suffix holds the leading one plus up to MaxPrefix more bits
  localparam int SUF_W  = MaxPrefix + 1;
  localparam int LEN_W  = MaxPrefix + 2;
  localparam int BITS_W = $clog2(BYTE_W + 1);

  // sequencer and byte shift register
  state_e               state_q, state_d;
  logic [BYTE_W-1:0]    byte_q, byte_d;
  logic                 fin_q, fin_d;
  logic [BITS_W-1:0]    bits_left_q, bits_left_d;

  // decode state
  logic                 next_ones_q, next_ones_d;
  logic                 in_suffix_q, in_suffix_d;
  logic [PC_W-1:0]      prefix_q, prefix_d;
  logic [PC_W-1:0]      left_q, left_d;
  logic [SUF_W-1:0]     suffix_q, suffix_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic                 finished_q, finished_d;

  logic [LIMIT_W-1:0]   limit_q, limit_d;

  // per-bit decode
  logic                 code_bit;
  logic                 prefix_sat;
  logic                 suffix_last;
  logic [SUF_W-1:0]     suffix_shift;
  logic [LEN_W-1:0]     len_base;
  logic [LEN_W-1:0]     run_len;
  logic [TOTAL_W-1:0]   run_len_ext;
  logic                 bit_is_run;
  logic                 bit_is_prefix_err;
  logic                 limit_hit;
  err_e                 total_err;

  // output stage hookup
  logic                 emit;
  result_t              emit_res;
  logic                 stall;
  ostage_ctrl_t         octrl;
  ostage_stat_t         ostat;

  logic                 cfg_wr;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[3] == REG_BIT_LIMIT);

  always_comb begin
    limit_d = limit_q;
    if (cfg_wr) begin
      limit_d = pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = (paddr[3] == REG_BIT_LIMIT) ? APB_DATA_W'(limit_q) : '0;

  // --------------------------------------------------------------------------
  // bit decode: msb of the byte shift register is the current code bit
  // --------------------------------------------------------------------------
  assign code_bit     = byte_q[BYTE_W-1];
  assign prefix_sat   = prefix_q > PC_W'(MaxPrefix);
  assign suffix_last  = left_q == PC_W'(1);
  assign suffix_shift = {suffix_q[SUF_W-2:0], code_bit};

  // a one bit after the prefix: a one run ends there, a zero run opens
  // its suffix; a zero run ends on the last suffix bit
  assign bit_is_prefix_err = !in_suffix_q && code_bit && prefix_sat;
  assign bit_is_run        = in_suffix_q ? suffix_last
                                         : (code_bit && !prefix_sat && next_ones_q);

  // every run length is some base plus one: prefix+1 for a one run,
  // suffix+1 for a zero run, and for a one-bit prefix-free zero code the
  // two-bit value minus one, which is the second bit plus one
  always_comb begin
    if (!in_suffix_q) begin
      len_base = LEN_W'(prefix_q);
    end else if (prefix_q != '0) begin
      len_base = LEN_W'(suffix_shift);
    end else begin
      len_base = LEN_W'(code_bit);
    end
  end

  assign run_len     = len_base + LEN_W'(1);
  assign run_len_ext = TOTAL_W'(run_len);

  assign limit_hit = total_q >= TOTAL_W'(limit_q);

  always_comb begin
    if (total_q[2:0] != 3'd0) begin
      total_err = ERR_NOT_BYTES;
    end else if ((limit_q != '0) && (total_q != TOTAL_W'(limit_q))) begin
      total_err = ERR_LIMIT;
    end else begin
      total_err = ERR_OK;
    end
  end

  // the sequencer and decode state hold while a word waits for room in the output stage
  assign stall = emit && !ostat.can_push;

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i && !finished_q) begin
          state_d = ST_BITS;
        end
      end
      ST_BITS: begin
        if (bit_is_prefix_err) begin
          state_d = ST_END;
        end else if (bit_is_run && (limit_q != '0)) begin
          state_d = ST_CHECK;
        end else if (bits_left_q == BITS_W'(1)) begin
          state_d = ST_END;
        end
      end
      ST_CHECK: begin
        if (limit_hit || (bits_left_q == '0)) begin
          state_d = ST_END;
        end else begin
          state_d = ST_BITS;
        end
      end
      ST_END: begin
        state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        // done once the held word has moved to the output register
        if (ostat.can_push) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    byte_d      = byte_q;
    fin_d       = fin_q;
    bits_left_d = bits_left_q;
    next_ones_d = next_ones_q;
    in_suffix_d = in_suffix_q;
    prefix_d    = prefix_q;
    left_d      = left_q;
    suffix_d    = suffix_q;
    total_d     = total_q;
    finished_d  = finished_q;
    emit        = 1'b0;
    emit_res    = '0;
    octrl.flush = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (finished_q) begin
            // stopped stream: bytes are dropped until the final one
            if (s_axis_tlast_i) begin
              next_ones_d = 1'b0;
              in_suffix_d = 1'b0;
              prefix_d    = '0;
              left_d      = '0;
              suffix_d    = '0;
              total_d     = '0;
              finished_d  = 1'b0;
            end
          end else begin
            byte_d      = s_axis_tdata_i;
            fin_d       = s_axis_tlast_i;
            bits_left_d = BITS_W'(BYTE_W);
          end
        end
      end

      ST_BITS: begin
        byte_d      = {byte_q[BYTE_W-2:0], 1'b0};
        bits_left_d = bits_left_q - BITS_W'(1);
        if (bit_is_prefix_err) begin
          emit                 = 1'b1;
          emit_res.stream_done = 1'b1;
          emit_res.error_code  = ERR_PREFIX;
          finished_d           = 1'b1;
        end else if (bit_is_run) begin
          emit                 = 1'b1;
          emit_res.run_length  = run_len_ext[RUN_LEN_W-1:0];
          emit_res.run_is_ones = !in_suffix_q;
          emit_res.run_valid   = 1'b1;
          total_d              = total_q + TOTAL_W'(len_base) + TOTAL_W'(1);
          next_ones_d          = !next_ones_q;
          in_suffix_d          = 1'b0;
          prefix_d             = '0;
          left_d               = '0;
          suffix_d             = '0;
        end else if (in_suffix_q) begin
          suffix_d = suffix_shift;
          left_d   = left_q - PC_W'(1);
        end else if (code_bit) begin
          // zero run code: the one bit opens the suffix
          in_suffix_d = 1'b1;
          suffix_d    = SUF_W'(1);
          left_d      = (prefix_q != '0) ? prefix_q : PC_W'(1);
        end else if (!prefix_sat) begin
          prefix_d = prefix_q + PC_W'(1);
        end
      end

      ST_CHECK: begin
        if (limit_hit) begin
          emit                 = 1'b1;
          emit_res.stream_done = 1'b1;
          emit_res.error_code  = total_err;
          finished_d           = 1'b1;
        end
      end

      ST_END: begin
        if (fin_q) begin
          if (!finished_q) begin
            emit                 = 1'b1;
            emit_res.stream_done = 1'b1;
            emit_res.error_code  = in_suffix_q ? ERR_INCOMPLETE : total_err;
          end
          // pending prefix zeros are padding; restart for the next stream
          next_ones_d = 1'b0;
          in_suffix_d = 1'b0;
          prefix_d    = '0;
          left_d      = '0;
          suffix_d    = '0;
          total_d     = '0;
          finished_d  = 1'b0;
        end
      end

      ST_FLUSH: begin
        octrl.flush = 1'b1;
      end

      default: begin
      end
    endcase

    octrl.push = emit;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bits_left_q <= '0;
      fin_q       <= 1'b0;
      next_ones_q <= 1'b0;
      in_suffix_q <= 1'b0;
      prefix_q    <= '0;
      left_q      <= '0;
      suffix_q    <= '0;
      total_q     <= '0;
      finished_q  <= 1'b0;
    end else if (!stall) begin
      state_q     <= state_d;
      bits_left_q <= bits_left_d;
      fin_q       <= fin_d;
      next_ones_q <= next_ones_d;
      in_suffix_q <= in_suffix_d;
      prefix_q    <= prefix_d;
      left_q      <= left_d;
      suffix_q    <= suffix_d;
      total_q     <= total_d;
      finished_q  <= finished_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else begin
      limit_q <= limit_d;
    end
  end

  // byte shift register carries payload only
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      byte_q <= byte_d;
    end
  end

  // --------------------------------------------------------------------------
  // output stage
  // --------------------------------------------------------------------------
  zorc_out_stage u_out_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (octrl),
    .res_i           (emit_res),
    .stat_o          (ostat),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
